### hdl/udf_pkg.sv
// Shared types and constants of the UDP destination filter with multicast group table.
// Used by the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package udf_pkg;

  // Group table size and derived widths.
  localparam int MaxGroups = 16;
  localparam int IdxW      = (MaxGroups > 1) ? $clog2(MaxGroups) : 1;
  localparam int CntW      = $clog2(MaxGroups + 1);

  // Field widths of the result.
  localparam int GrpCntW = 5;
  localparam int StatusW = 4;

  // One table entry: group address high, group address low, scope id.
  localparam int EntryW = 64 + 64 + 32;

  // Protocol and header constants.
  localparam logic [7:0]  UdpProto  = 8'd17;
  localparam logic [7:0]  McastByte = 8'hFF;
  localparam logic [15:0] UdpHdrLen = 16'd8;

  // Request kinds.
  typedef enum logic [1:0] {
    ReqData  = 2'd0,
    ReqJoin  = 2'd1,
    ReqLeave = 2'd2,
    ReqBad   = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StOk        = 4'd0,
    StProto     = 4'd1,
    StFamily    = 4'd2,
    StUnbound   = 4'd3,
    StScope     = 4'd4,
    StNotMember = 4'd5,
    StAddr      = 4'd6,
    StPort      = 4'd7,
    StLength    = 4'd8,
    StShut      = 4'd9,
    StFull      = 4'd10
  } status_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgIsIpv6     = 3'd0,
    CfgBound      = 3'd1,
    CfgLocalPort  = 3'd2,
    CfgLocalAddr4 = 3'd3,
    CfgAddr6Hi    = 3'd4,
    CfgAddr6Lo    = 3'd5,
    CfgLocalScope = 3'd6,
    CfgReadShut   = 3'd7
  } cfg_idx_e;

  // Payload of one request transaction.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  protocol;
    logic        dest_is_ipv4;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] scope;
    logic [15:0] dst_port;
    logic [15:0] udp_length;
    logic [15:0] datagram_size;
  } req_t;

  // Payload of one result transaction.
  typedef struct packed {
    logic                accepted;
    status_e             status;
    logic [15:0]         payload_length;
    logic [GrpCntW-1:0]  group_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    walk_start;
    logic    shift_start;
    logic    walk_scan;
    logic    walk_shift;
    logic    join_wr;
    logic    cnt_dec;
    logic    load_res;
    status_e res_st;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_e    req_kind;
    logic    read_shut;
    status_e pre_st;
    logic    need_member;
    status_e tail_st;
    logic    hit;
    logic    walk_done;
    logic    full;
    logic    out_busy;
  } stat_t;

endpackage

`default_nettype wire

### hdl/udf_req_if.sv
// Request channel of the UDP destination filter: valid, ready and the item fields.
// Depends on nothing.
`default_nettype none

interface udf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  protocol;
  logic        dest_is_ipv4;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [31:0] scope;
  logic [15:0] dst_port;
  logic [15:0] udp_length;
  logic [15:0] datagram_size;

  modport source (
    output valid, req_type, protocol, dest_is_ipv4, addr_hi, addr_lo, scope,
           dst_port, udp_length, datagram_size,
    input  ready
  );

  modport sink (
    input  valid, req_type, protocol, dest_is_ipv4, addr_hi, addr_lo, scope,
           dst_port, udp_length, datagram_size,
    output ready
  );
endinterface

`default_nettype wire

### hdl/udf_rsp_if.sv
// Result channel of the UDP destination filter: valid, ready and the result fields.
// Depends on nothing.
`default_nettype none

interface udf_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  status;
  logic [15:0] payload_length;
  logic [4:0]  group_count;

  modport source (
    output valid, accepted, status, payload_length, group_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, status, payload_length, group_count,
    output ready
  );
endinterface

`default_nettype wire

### hdl/udp_dest_filter_mcast_table.sv
// UDP destination filter for one bound endpoint, with a multicast group table (top level).
// Depends on udf_pkg, udf_req_if, udf_rsp_if, udf_ctrl, udf_dpath and udf_ram.
//
// Each request transaction is a datagram to check, a group join or a group leave, and
// yields exactly one result transaction. Items are handled one at a time. A datagram that
// needs the membership lookup, or a join, walks the joined entries of the group table,
// which sits in a RAM with one registered read port and is walked one entry per cycle.
// A unicast or rejected datagram, or a refused request, needs no walk. A leave that finds
// its group then compacts only the entries behind it through the same read port. The result
// sits in an output register; a new request is taken as soon as the previous item has been
// handed to that register, so a result sink that holds ready low stalls the flow.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write them only while no item is in flight, which the block itself does not enforce.
`default_nettype none

module udp_dest_filter_mcast_table
  import udf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  udf_req_if.sink          req_if,
  udf_rsp_if.source        rsp_if
);

  req_t  req;
  rsp_t  rsp;
  cmd_t  cmd;
  stat_t stat;
  logic  rsp_vld;
  logic  req_ready;

  // Gather the request transaction fields.
  always_comb begin
    req.req_type      = req_if.req_type;
    req.protocol      = req_if.protocol;
    req.dest_is_ipv4  = req_if.dest_is_ipv4;
    req.addr_hi       = req_if.addr_hi;
    req.addr_lo       = req_if.addr_lo;
    req.scope         = req_if.scope;
    req.dst_port      = req_if.dst_port;
    req.udp_length    = req_if.udp_length;
    req.datagram_size = req_if.datagram_size;
  end

  assign req_if.ready = req_ready;

  udf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  udf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_vld_o   (rsp_vld),
    .rsp_ready_i (rsp_if.ready),
    .rsp_o       (rsp)
  );

  // Drive the result transaction fields.
  assign rsp_if.valid          = rsp_vld;
  assign rsp_if.accepted       = rsp.accepted;
  assign rsp_if.status         = rsp.status;
  assign rsp_if.payload_length = rsp.payload_length;
  assign rsp_if.group_count    = rsp.group_count;

endmodule

`default_nettype wire

### hdl/udf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the multicast group table; no dependencies.
`default_nettype none

module udf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                            wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/udf_ctrl.sv
// Controller of the UDP destination filter: sequences check, table walk, compaction
// and result load. Depends on udf_pkg; drives the datapath through cmd_t.
`default_nettype none

module udf_ctrl
  import udf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  req_valid_i,
  output logic       req_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SCheck = 5'b00010,
    SScan  = 5'b00100,
    SShift = 5'b01000,
    SDone  = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  status_e res_st_q, res_st_d;

  // Next-state and command logic.
  always_comb begin
    state_d       = state_q;
    res_st_d      = res_st_q;
    cmd_o         = '0;
    cmd_o.res_st  = res_st_q;
    req_ready_o   = (state_q == SIdle);

    unique case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = SCheck;
        end
      end

      SCheck: begin
        unique case (stat_i.req_kind)
          ReqData: begin
            if (stat_i.pre_st != StOk) begin
              res_st_d = stat_i.pre_st;
              state_d  = SDone;
            end else if (stat_i.need_member) begin
              cmd_o.walk_start = 1'b1;
              state_d          = SScan;
            end else begin
              res_st_d = stat_i.tail_st;
              state_d  = SDone;
            end
          end
          ReqJoin, ReqLeave: begin
            if (stat_i.read_shut) begin
              res_st_d = StShut;
              state_d  = SDone;
            end else begin
              cmd_o.walk_start = 1'b1;
              state_d          = SScan;
            end
          end
          ReqBad: begin
            res_st_d = StShut;
            state_d  = SDone;
          end
        endcase
      end

      // Walk the table looking for a matching entry.
      SScan: begin
        cmd_o.walk_scan = 1'b1;
        if (stat_i.hit) begin
          unique case (stat_i.req_kind)
            ReqData: begin
              res_st_d = stat_i.tail_st;
              state_d  = SDone;
            end
            ReqLeave: begin
              cmd_o.shift_start = 1'b1;
              state_d           = SShift;
            end
            ReqJoin, ReqBad: begin
              res_st_d = StOk;
              state_d  = SDone;
            end
          endcase
        end else if (stat_i.walk_done) begin
          unique case (stat_i.req_kind)
            ReqData: begin
              res_st_d = StNotMember;
            end
            ReqJoin: begin
              if (stat_i.full) begin
                res_st_d = StFull;
              end else begin
                cmd_o.join_wr = 1'b1;
                res_st_d      = StOk;
              end
            end
            ReqLeave, ReqBad: begin
              res_st_d = StOk;
            end
          endcase
          state_d = SDone;
        end
      end

      // Close the gap left by a removed group.
      SShift: begin
        cmd_o.walk_shift = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.cnt_dec = 1'b1;
          res_st_d      = StOk;
          state_d       = SDone;
        end
      end

      SDone: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_res = 1'b1;
          state_d        = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      res_st_q <= StOk;
    end else begin
      state_q  <= state_d;
      res_st_q <= res_st_d;
    end
  end

  // Compaction only ever follows a found entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SShift) |-> stat_i.hit)
    else $error("compaction running without a matching entry");

  // A leave that finds its group goes on to compaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) && stat_i.hit && (stat_i.req_kind == ReqLeave) |=> (state_q == SShift))
    else $error("leave hit did not start compaction");

endmodule

`default_nettype wire

### hdl/udf_dpath.sv
// Datapath of the UDP destination filter: configuration registers, item registers,
// datagram checks, group table walk and compaction, and the result register.
// Depends on udf_pkg and udf_ram.
`default_nettype none

module udf_dpath
  import udf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire req_t        req_i,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  output logic             rsp_vld_o,
  input  wire logic        rsp_ready_i,
  output rsp_t             rsp_o
);

  // Configuration registers.
  logic        is_ipv6_q;
  logic        bound_q;
  logic [15:0] local_port_q;
  logic [31:0] local_addr4_q;
  logic [63:0] addr6_hi_q;
  logic [63:0] addr6_lo_q;
  logic [31:0] local_scope_q;
  logic        read_shut_q;

  // Item registers; the key holds the mapped address for an IPv4 datagram on IPv6.
  req_e        kind_q;
  logic [7:0]  protocol_q;
  logic        dest4_q;
  logic        mapped_q;
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [31:0] key_sc_q;
  logic [15:0] port_q;
  logic [15:0] ulen_q;
  logic [15:0] dsize_q;

  // Table walk state.
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] ptr_q;
  logic            pend_q;
  logic [IdxW-1:0] pend_idx_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;

  // Result register.
  logic rsp_vld_q;
  rsp_t rsp_q;

  logic              map_now;
  logic              issue;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  logic [63:0]       ent_hi;
  logic [63:0]       ent_lo;
  logic [31:0]       ent_sc;
  logic              addr_eq;
  logic              match;
  logic              mcast;
  status_e           pre_st;
  status_e           tail_st;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_ipv6_q     <= 1'b0;
      bound_q       <= 1'b0;
      local_port_q  <= '0;
      local_addr4_q <= '0;
      addr6_hi_q    <= '0;
      addr6_lo_q    <= '0;
      local_scope_q <= '0;
      read_shut_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgIsIpv6:     is_ipv6_q     <= cfg_data_i[0];
        CfgBound:      bound_q       <= cfg_data_i[0];
        CfgLocalPort:  local_port_q  <= cfg_data_i[15:0];
        CfgLocalAddr4: local_addr4_q <= cfg_data_i[31:0];
        CfgAddr6Hi:    addr6_hi_q    <= cfg_data_i;
        CfgAddr6Lo:    addr6_lo_q    <= cfg_data_i;
        CfgLocalScope: local_scope_q <= cfg_data_i[31:0];
        CfgReadShut:   read_shut_q   <= cfg_data_i[0];
      endcase
    end
  end

  // Item capture, with the IPv4-mapped address formed on the way in.
  assign map_now = (req_e'(req_i.req_type) == ReqData) && req_i.dest_is_ipv4 && is_ipv6_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q     <= req_e'(req_i.req_type);
      protocol_q <= req_i.protocol;
      dest4_q    <= req_i.dest_is_ipv4;
      mapped_q   <= map_now;
      key_hi_q   <= map_now ? 64'd0 : req_i.addr_hi;
      key_lo_q   <= map_now ? {32'h0000_FFFF, req_i.addr_lo[31:0]} : req_i.addr_lo;
      key_sc_q   <= map_now ? 32'd0 : req_i.scope;
      port_q     <= req_i.dst_port;
      ulen_q     <= req_i.udp_length;
      dsize_q    <= req_i.datagram_size;
    end
  end

  // Datagram checks ahead of the membership lookup.
  assign mcast = (key_hi_q[63:56] == McastByte);

  always_comb begin
    pre_st = StOk;
    priority if (protocol_q != UdpProto) begin
      pre_st = StProto;
    end else if (!dest4_q && !is_ipv6_q) begin
      pre_st = StFamily;
    end else if (!bound_q) begin
      pre_st = StUnbound;
    end else if (!is_ipv6_q) begin
      if ((local_addr4_q != 32'd0) && (local_addr4_q != key_lo_q[31:0])) begin
        pre_st = StAddr;
      end
    end else if ((local_scope_q != 32'd0) && (key_sc_q != local_scope_q)) begin
      pre_st = StScope;
    end else if (!mcast && ((addr6_hi_q != 64'd0) || (addr6_lo_q != 64'd0)) &&
                 ((addr6_hi_q != key_hi_q) || (addr6_lo_q != key_lo_q)) && !mapped_q) begin
      pre_st = StAddr;
    end else begin
      pre_st = StOk;
    end
  end

  // Port and length checks after the address stage.
  always_comb begin
    tail_st = StOk;
    priority if (port_q != local_port_q) begin
      tail_st = StPort;
    end else if ((ulen_q < UdpHdrLen) || (ulen_q > dsize_q)) begin
      tail_st = StLength;
    end else begin
      tail_st = StOk;
    end
  end

  // Entry compare: membership for a datagram, exact match for join and leave.
  assign ent_hi  = ram_rdata[EntryW-1 -: 64];
  assign ent_lo  = ram_rdata[95:32];
  assign ent_sc  = ram_rdata[31:0];
  assign addr_eq = (ent_hi == key_hi_q) && (ent_lo == key_lo_q);
  assign match   = addr_eq && ((ent_sc == key_sc_q) ||
                               ((kind_q == ReqData) && (ent_sc == 32'd0)));

  // Read issue and write port of the table.
  assign issue     = ((cmd_i.walk_scan && !hit_q) || cmd_i.walk_shift) && (ptr_q < cnt_q);
  assign ram_we    = cmd_i.join_wr || (cmd_i.walk_shift && pend_q);
  assign ram_waddr = cmd_i.join_wr ? cnt_q[IdxW-1:0] : (pend_idx_q - IdxW'(1));
  assign ram_wdata = cmd_i.join_wr ? {key_hi_q, key_lo_q, key_sc_q} : ram_rdata;

  udf_ram #(
    .Width (EntryW),
    .Depth (MaxGroups)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Walk pointer, read pipeline flag and hit capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
    end else begin
      if (cmd_i.walk_start) begin
        ptr_q  <= '0;
        pend_q <= 1'b0;
        hit_q  <= 1'b0;
      end else if (cmd_i.shift_start) begin
        ptr_q  <= CntW'(hit_idx_q) + CntW'(1);
        pend_q <= 1'b0;
      end else if (cmd_i.walk_scan || cmd_i.walk_shift) begin
        if (issue) begin
          ptr_q <= ptr_q + CntW'(1);
        end
        pend_q     <= issue;
        pend_idx_q <= ptr_q[IdxW-1:0];
        if (cmd_i.walk_scan && pend_q && match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= pend_idx_q;
        end
      end
    end
  end

  // Joined group count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.join_wr) begin
      cnt_q <= cnt_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Result register; it frees up when the sink takes the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      rsp_q.accepted       <= (cmd_i.res_st == StOk);
      rsp_q.status         <= cmd_i.res_st;
      rsp_q.payload_length <= ((cmd_i.res_st == StOk) && (kind_q == ReqData)) ?
                              (ulen_q - UdpHdrLen) : 16'd0;
      rsp_q.group_count    <= GrpCntW'(cnt_q);
    end
  end

  assign rsp_vld_o = rsp_vld_q;
  assign rsp_o     = rsp_q;

  // Status to the controller.
  always_comb begin
    stat_o             = '0;
    stat_o.req_kind    = kind_q;
    stat_o.read_shut   = read_shut_q;
    stat_o.pre_st      = pre_st;
    stat_o.need_member = is_ipv6_q && mcast;
    stat_o.tail_st     = tail_st;
    stat_o.hit         = hit_q;
    stat_o.walk_done   = !pend_q && !(ptr_q < cnt_q);
    stat_o.full        = (cnt_q == CntW'(MaxGroups));
    stat_o.out_busy    = rsp_vld_q && !rsp_ready_i;
  end

  // The group count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxGroups))
    else $error("group count beyond table size");

  // A leave only removes from a table that holds groups.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (cnt_q != '0) && hit_q)
    else $error("group removed from an empty table or without a match");

  // An accepted result carries status ok and only then a payload length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> (rsp_q.accepted == (rsp_q.status == StOk)) &&
                  ((rsp_q.payload_length == 16'd0) || rsp_q.accepted))
    else $error("result accept flag disagrees with status");

endmodule

`default_nettype wire
